[design/rsp_pkg.sv]
// ----------------------------------------------------------------------------
// Radial sine pattern package
// Shared constants, register indexes and the sine table entry function for
// the radial sine pattern generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rsp_pkg;

  // Default structural parameters.
  localparam int DEF_COORD_BITS      = 11;
  localparam int DEF_SINE_INDEX_BITS = 10;

  // Fixed field widths.
  localparam int PHASE_BITS     = 16;
  localparam int FREQ_BITS      = 24;
  localparam int COLOR_BITS     = 8;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;

  // Distance is unsigned with four fraction bits.
  localparam int DIST_FRAC_BITS = 4;

  // The distance times frequency product is shifted right by this much.
  localparam int ANGLE_SHIFT = 12;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_COL = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_ROW = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FREQ_RED   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FREQ_GREEN = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FREQ_BLUE  = 3'd4;

  // Register reset values.
  localparam int RST_CENTER_COL = 400;
  localparam int RST_CENTER_ROW = 300;
  localparam logic [FREQ_BITS-1:0] RST_FREQ_RED   = 24'd133509;
  localparam logic [FREQ_BITS-1:0] RST_FREQ_GREEN = 24'd80105;
  localparam logic [FREQ_BITS-1:0] RST_FREQ_BLUE  = 24'd26702;

  // Fixed-point constants of the sine table, Q2.30.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  // One table byte for quarter-wave position r (0 to a quarter turn).
  // The sine is a ninth-order odd Taylor series; neg_half selects the
  // lower half of the wave. Evaluated at elaboration only.
  function automatic logic [COLOR_BITS-1:0] sine_entry(input int sine_index_bits,
                                                       input logic neg_half,
                                                       input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    x = (r * HALF_PI_Q30) >> (sine_index_bits - 2);
    t = x;
    s = x;
    t = (t * x) >> 30;
    t = ((t * x) >> 30) / 64'd6;
    s = (s >= t) ? s - t : 64'd0;
    t = (t * x) >> 30;
    t = ((t * x) >> 30) / 64'd20;
    s = s + t;
    t = (t * x) >> 30;
    t = ((t * x) >> 30) / 64'd42;
    s = (s >= t) ? s - t : 64'd0;
    t = (t * x) >> 30;
    t = ((t * x) >> 30) / 64'd72;
    s = s + t;
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    v = neg_half ? ONE_Q30 - s : ONE_Q30 + s;
    return COLOR_BITS'((v * 64'd255) >> 31);
  endfunction

endpackage

`default_nettype wire

[design/rsp_dist.sv]
// ----------------------------------------------------------------------------
// Radial sine pattern distance front end
// Three register stages: absolute offsets, squares, and the scaled sum of
// squares that feeds the square root pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_dist #(
  parameter int COORD_BITS = rsp_pkg::DEF_COORD_BITS,
  parameter int ROOT_BITS  = rsp_pkg::DEF_COORD_BITS + 1 + rsp_pkg::DIST_FRAC_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_vld,
  input  wire logic [COORD_BITS-1:0]          in_col,
  input  wire logic [COORD_BITS-1:0]          in_row,
  input  wire logic [rsp_pkg::PHASE_BITS-1:0] in_phase,
  input  wire logic [COORD_BITS-1:0]          center_col,
  input  wire logic [COORD_BITS-1:0]          center_row,
  output logic                                out_vld,
  output logic [2*ROOT_BITS-1:0]              out_rad,
  output logic [rsp_pkg::PHASE_BITS-1:0]      out_phase
);

  localparam int SqBits  = 2 * COORD_BITS;
  localparam int SumBits = SqBits + 1;
  localparam int RadBits = 2 * ROOT_BITS;

  logic                           vld1_r, vld2_r, vld3_r;
  logic [COORD_BITS-1:0]          dx_r, dy_r;
  logic [COORD_BITS-1:0]          dx_nxt, dy_nxt;
  logic [SqBits-1:0]              sqx_r, sqy_r;
  logic [SumBits-1:0]             sum_nxt;
  logic [RadBits-1:0]             rad_r;
  logic [rsp_pkg::PHASE_BITS-1:0] ph1_r, ph2_r, ph3_r;

  // Absolute offsets from the center.
  always_comb begin
    dx_nxt = (in_col >= center_col) ? in_col - center_col : center_col - in_col;
    dy_nxt = (in_row >= center_row) ? in_row - center_row : center_row - in_row;
  end

  // The sum of squares; it is scaled below so the root carries the fraction bits.
  assign sum_nxt = SumBits'(sqx_r) + SumBits'(sqy_r);

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    ph1_r <= in_phase;
    sqx_r <= SqBits'(dx_r) * SqBits'(dx_r);
    sqy_r <= SqBits'(dy_r) * SqBits'(dy_r);
    ph2_r <= ph1_r;
    rad_r <= RadBits'({sum_nxt, {(2 * rsp_pkg::DIST_FRAC_BITS){1'b0}}});
    ph3_r <= ph2_r;
  end

  assign out_vld   = vld3_r;
  assign out_rad   = rad_r;
  assign out_phase = ph3_r;

endmodule

`default_nettype wire

[design/rsp_isqrt.sv]
// ----------------------------------------------------------------------------
// Radial sine pattern square root pipeline
// Restoring integer square root, one root bit per register stage, with a
// tag word carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_isqrt #(
  parameter int ROOT_BITS = rsp_pkg::DEF_COORD_BITS + 1 + rsp_pkg::DIST_FRAC_BITS,
  parameter int TAG_BITS  = rsp_pkg::PHASE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_vld,
  input  wire logic [2*ROOT_BITS-1:0] in_rad,
  input  wire logic [TAG_BITS-1:0]    in_tag,
  output logic                        out_vld,
  output logic [ROOT_BITS-1:0]        out_root,
  output logic [TAG_BITS-1:0]         out_tag
);

  localparam int RadBits = 2 * ROOT_BITS;
  localparam int RemBits = ROOT_BITS + 2;

  logic                 vld_r  [ROOT_BITS];
  logic [RemBits-1:0]   rem_r  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_r [ROOT_BITS];
  logic [RadBits-1:0]   rad_r  [ROOT_BITS];
  logic [TAG_BITS-1:0]  tag_r  [ROOT_BITS];

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_stage
    logic                 vld_in;
    logic [RemBits-1:0]   rem_in;
    logic [ROOT_BITS-1:0] root_in;
    logic [RadBits-1:0]   rad_in;
    logic [TAG_BITS-1:0]  tag_in;
    logic [RemBits-1:0]   rem_sh;
    logic [RemBits-1:0]   trial;
    logic                 fits;
    logic [RemBits-1:0]   rem_nxt;
    logic [ROOT_BITS-1:0] root_nxt;

    if (i == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign tag_in  = tag_r[i-1];
    end

    // Bring down the next radicand bit pair and try the next root bit.
    always_comb begin
      rem_sh   = {rem_in[ROOT_BITS-1:0], rad_in[RadBits-1 -: 2]};
      trial    = {root_in, 2'b01};
      fits     = (rem_sh >= trial);
      rem_nxt  = fits ? rem_sh - trial : rem_sh;
      root_nxt = {root_in[ROOT_BITS-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= rem_nxt;
      root_r[i] <= root_nxt;
      rad_r[i]  <= {rad_in[RadBits-3:0], 2'b00};
      tag_r[i]  <= tag_in;
    end
  end

  assign out_vld  = vld_r[ROOT_BITS-1];
  assign out_root = root_r[ROOT_BITS-1];
  assign out_tag  = tag_r[ROOT_BITS-1];

endmodule

`default_nettype wire

[design/rsp_channel.sv]
// ----------------------------------------------------------------------------
// Radial sine pattern color channel
// Two register stages: distance times frequency, then phase add and
// quarter-wave sine table lookup into one color byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_channel #(
  parameter int ROOT_BITS       = rsp_pkg::DEF_COORD_BITS + 1 + rsp_pkg::DIST_FRAC_BITS,
  parameter int SINE_INDEX_BITS = rsp_pkg::DEF_SINE_INDEX_BITS
) (
  input  wire logic                                  clk,
  input  wire logic [ROOT_BITS-1:0]                  radius,
  input  wire logic [rsp_pkg::PHASE_BITS-1:0]        phase,
  input  wire logic signed [rsp_pkg::FREQ_BITS-1:0]  freq,
  output logic [rsp_pkg::COLOR_BITS-1:0]             color
);

  localparam int ProdBits = ROOT_BITS + 1 + rsp_pkg::FREQ_BITS;
  localparam int Quarter  = 2 ** (SINE_INDEX_BITS - 2);
  localparam int IdxBits  = SINE_INDEX_BITS - 1;
  localparam int PhBits   = rsp_pkg::PHASE_BITS;

  logic signed [ProdBits-1:0]     prod_nxt;
  logic signed [ProdBits-1:0]     prod_r;
  logic [PhBits-1:0]              phase_r;
  logic [PhBits-1:0]              angle;
  logic [SINE_INDEX_BITS-1:0]     sidx;
  logic [1:0]                     quad;
  logic [SINE_INDEX_BITS-3:0]     rpos;
  logic [IdxBits-1:0]             tidx;
  logic [rsp_pkg::COLOR_BITS-1:0] color_nxt;
  logic [rsp_pkg::COLOR_BITS-1:0] color_r;
  logic [rsp_pkg::COLOR_BITS-1:0] rom_pos [Quarter+1];
  logic [rsp_pkg::COLOR_BITS-1:0] rom_neg [Quarter+1];

  // Quarter-wave tables for the upper and lower halves of the wave.
  for (genvar j = 0; j <= Quarter; j++) begin : g_rom
    assign rom_pos[j] = rsp_pkg::sine_entry(SINE_INDEX_BITS, 1'b0, 64'(j));
    assign rom_neg[j] = rsp_pkg::sine_entry(SINE_INDEX_BITS, 1'b1, 64'(j));
  end

  // Signed product of the unsigned distance and the frequency.
  assign prod_nxt = $signed({1'b0, radius}) * freq;

  // Angle in units of 1/65536 turn, then quadrant and mirrored position.
  always_comb begin
    angle = prod_r[rsp_pkg::ANGLE_SHIFT +: PhBits] + phase_r;
    sidx  = angle[PhBits-1 -: SINE_INDEX_BITS];
    quad  = sidx[SINE_INDEX_BITS-1 -: 2];
    rpos  = sidx[SINE_INDEX_BITS-3:0];
    tidx  = quad[0] ? IdxBits'(Quarter) - {1'b0, rpos} : {1'b0, rpos};
    color_nxt = quad[1] ? rom_neg[tidx] : rom_pos[tidx];
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    phase_r <= phase;
    color_r <= color_nxt;
  end

  assign color = color_r;

endmodule

`default_nettype wire

[design/radial_sine_pattern_generator.sv]
// ----------------------------------------------------------------------------
// Radial sine pattern generator
// One RGB pixel of a radial sine ripple per word, from pixel coordinates
// and a frame phase, around a configurable center.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                                Handshake
//   input    in_col, in_row, in_phase             start high, busy low
//   result   out_pixel_color                      out_strobe, one cycle
//   config   cfg_index, cfg_data                  cfg_we, no wait
//
// A new word is taken in every cycle; busy is always low.
// The pipeline has three distance stages, one square root stage per root
// bit, and two stages per channel. Reset clears the valid bits of the
// pipeline and loads the register defaults. The receiver cannot stall, so
// nothing ever waits in the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_sine_pattern_generator #(
  parameter int COORD_BITS      = rsp_pkg::DEF_COORD_BITS,
  parameter int SINE_INDEX_BITS = rsp_pkg::DEF_SINE_INDEX_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [COORD_BITS-1:0]               in_col,
  input  wire logic [COORD_BITS-1:0]               in_row,
  input  wire logic [rsp_pkg::PHASE_BITS-1:0]      in_phase,
  output logic                                     out_strobe,
  output logic [3*rsp_pkg::COLOR_BITS-1:0]         out_pixel_color,
  input  wire logic                                cfg_we,
  input  wire logic [rsp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [rsp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int RootBits = COORD_BITS + 1 + rsp_pkg::DIST_FRAC_BITS;
  localparam int Latency  = RootBits + 5;
  localparam int FreqBits = rsp_pkg::FREQ_BITS;

  logic [COORD_BITS-1:0]          center_col_r, center_row_r;
  logic [FreqBits-1:0]            freq_red_r, freq_green_r, freq_blue_r;
  logic                           accept;
  logic                           rad_vld;
  logic [2*RootBits-1:0]          rad;
  logic [rsp_pkg::PHASE_BITS-1:0] rad_phase;
  logic                           sq_vld;
  logic [RootBits-1:0]            radius;
  logic [rsp_pkg::PHASE_BITS-1:0] sq_phase;
  logic [1:0]                     ch_vld_r;
  logic [rsp_pkg::COLOR_BITS-1:0] red, green, blue;

  // The pipeline never holds off a word.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_col_r <= COORD_BITS'(rsp_pkg::RST_CENTER_COL);
      center_row_r <= COORD_BITS'(rsp_pkg::RST_CENTER_ROW);
      freq_red_r   <= rsp_pkg::RST_FREQ_RED;
      freq_green_r <= rsp_pkg::RST_FREQ_GREEN;
      freq_blue_r  <= rsp_pkg::RST_FREQ_BLUE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsp_pkg::REG_CENTER_COL: center_col_r <= cfg_data[COORD_BITS-1:0];
        rsp_pkg::REG_CENTER_ROW: center_row_r <= cfg_data[COORD_BITS-1:0];
        rsp_pkg::REG_FREQ_RED:   freq_red_r   <= cfg_data[FreqBits-1:0];
        rsp_pkg::REG_FREQ_GREEN: freq_green_r <= cfg_data[FreqBits-1:0];
        rsp_pkg::REG_FREQ_BLUE:  freq_blue_r  <= cfg_data[FreqBits-1:0];
        default: ;
      endcase
    end
  end

  // Offsets, squares and the scaled radicand.
  rsp_dist #(
    .COORD_BITS (COORD_BITS),
    .ROOT_BITS  (RootBits)
  ) u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (accept),
    .in_col     (in_col),
    .in_row     (in_row),
    .in_phase   (in_phase),
    .center_col (center_col_r),
    .center_row (center_row_r),
    .out_vld    (rad_vld),
    .out_rad    (rad),
    .out_phase  (rad_phase)
  );

  // Distance in Q.4 through the square root pipeline.
  rsp_isqrt #(
    .ROOT_BITS (RootBits),
    .TAG_BITS  (rsp_pkg::PHASE_BITS)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (rad_vld),
    .in_rad   (rad),
    .in_tag   (rad_phase),
    .out_vld  (sq_vld),
    .out_root (radius),
    .out_tag  (sq_phase)
  );

  // One channel each for red, green and blue.
  rsp_channel #(
    .ROOT_BITS       (RootBits),
    .SINE_INDEX_BITS (SINE_INDEX_BITS)
  ) u_red (
    .clk    (clk),
    .radius (radius),
    .phase  (sq_phase),
    .freq   ($signed(freq_red_r)),
    .color  (red)
  );

  rsp_channel #(
    .ROOT_BITS       (RootBits),
    .SINE_INDEX_BITS (SINE_INDEX_BITS)
  ) u_green (
    .clk    (clk),
    .radius (radius),
    .phase  (sq_phase),
    .freq   ($signed(freq_green_r)),
    .color  (green)
  );

  rsp_channel #(
    .ROOT_BITS       (RootBits),
    .SINE_INDEX_BITS (SINE_INDEX_BITS)
  ) u_blue (
    .clk    (clk),
    .radius (radius),
    .phase  (sq_phase),
    .freq   ($signed(freq_blue_r)),
    .color  (blue)
  );

  // Valid bits that follow the two channel stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_vld_r <= 2'b00;
    end else begin
      ch_vld_r <= {ch_vld_r[0], sq_vld};
    end
  end

  assign out_strobe      = ch_vld_r[1];
  assign out_pixel_color = {red, green, blue};

  // A strobe always comes from a word that left the square root stage.
  a_strobe_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(sq_vld, 2))
    else $error("result strobe without a matching word in the pipeline");

  // Every accepted word gives its result after the fixed latency.
  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(Latency) out_strobe)
    else $error("accepted word did not produce a result on time");

  // Reset empties the pipeline.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

endmodule

`default_nettype wire
